// File: design/date_check_and_weekday_assert.svh
// Assertion macros shared by the date check and weekday design.
`ifndef DATE_CHECK_AND_WEEKDAY_ASSERT_SVH
`define DATE_CHECK_AND_WEEKDAY_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcw_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CentW  = 8;
  localparam int unsigned RemW   = 7;
  localparam int unsigned SumW   = 11;
  localparam int unsigned WdayW  = 3;

  localparam logic [YearW-1:0]  FirstYear  = 14'd1582;
  localparam logic [YearW-1:0]  LastYear   = 14'd9999;
  localparam logic [MonthW-1:0] FirstMonth = 4'd10;
  localparam logic [DayW-1:0]   LastJulDay = 5'd14;
  localparam logic [MonthW-1:0] MarchMonth = 4'd3;

  // x / 100 == (x * 5243) >> 19 for every 14-bit x
  localparam logic [12:0]       Recip100   = 13'd5243;
  localparam int unsigned       RecipShift = 19;
  localparam logic [YearW-1:0]  Century    = 14'd100;
  localparam logic [RemW-1:0]   LastYy     = 7'd99;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [CentW-1:0]  cent;
    logic              in_range;
  } div_t;

  typedef struct packed {
    logic              ok;
    logic [DayW-1:0]   day;
    logic [4:0]        moff;
    logic [CentW-1:0]  cc;
    logic [RemW-1:0]   yy;
  } chk_t;

  typedef struct packed {
    logic              ok;
    logic [SumW-1:0]   sum;
  } sum_t;

  typedef struct packed {
    logic              ok;
    logic [WdayW-1:0]  wday;
  } res_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // (13 * m - 1) / 5 with March as shifted month 1
  function automatic logic [4:0] month_offset(input logic [MonthW-1:0] month);
    logic [4:0] off;
    case (month)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // Fold by 64 == 1 and 8 == 1 (mod 7), then one conditional subtract.
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] s);
    logic [6:0] t1;
    logic [4:0] t2;
    logic [3:0] t3;
    logic [3:0] t4;
    t1 = 7'(s[10:6]) + 7'(s[5:0]);
    t2 = 5'(t1[6:3]) + 5'(t1[2:0]);
    t3 = 4'(t2[4:3]) + 4'(t2[2:0]);
    t4 = (t3 >= 4'd7) ? t3 - 4'd7 : t3;
    return t4[2:0];
  endfunction

endpackage

`default_nettype wire

// File: design/dcw_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: split off the century by reciprocal multiply, check the Gregorian date range.
module dcw_div import dcw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  date_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output div_t  data_o
);

  logic        valid_q;
  div_t        data_d, data_q;
  logic [26:0] prod;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod             = 27'(data_i.year) * 27'(Recip100);
    data_d.year      = data_i.year;
    data_d.month     = data_i.month;
    data_d.day       = data_i.day;
    data_d.cent      = prod[RecipShift +: CentW];
    data_d.in_range  = (data_i.year > FirstYear && data_i.year <= LastYear) ||
                       (data_i.year == FirstYear &&
                        (data_i.month > FirstMonth ||
                         (data_i.month == FirstMonth && data_i.day > LastJulDay)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/dcw_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: leap year, month length, date check, shift Jan/Feb to prior year.
module dcw_check import dcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output chk_t data_o
);

  logic             valid_q;
  chk_t             data_d, data_q;
  logic [YearW-1:0] rem_full;
  logic [RemW-1:0]  rem;
  logic             leap;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rem_full = data_i.year - YearW'(data_i.cent) * Century;
    rem      = rem_full[RemW-1:0];
    leap     = (data_i.year[1:0] == 2'd0) && (rem != '0 || data_i.cent[1:0] == 2'd0);

    data_d.ok   = data_i.in_range && data_i.day != '0 &&
                  data_i.day <= month_len(data_i.month, leap);
    data_d.day  = data_i.day;
    data_d.moff = month_offset(data_i.month);
    if (data_i.month < MarchMonth) begin
      if (rem == '0) begin
        data_d.cc = data_i.cent - 8'd1;
        data_d.yy = LastYy;
      end else begin
        data_d.cc = data_i.cent;
        data_d.yy = rem - 7'd1;
      end
    end else begin
      data_d.cc = data_i.cent;
      data_d.yy = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/dcw_sum.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: Gauss sum; 5*c stands in for -2*c modulo 7.
module dcw_sum import dcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  chk_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output sum_t data_o
);

  logic valid_q;
  sum_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.ok  = data_i.ok;
    data_d.sum = SumW'(data_i.day) + SumW'(data_i.moff) + SumW'(data_i.yy) +
                 SumW'(data_i.yy >> 2) + SumW'(data_i.cc >> 2) +
                 SumW'(data_i.cc) * SumW'(5);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/dcw_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 4: reduce modulo 7 into the output register, zero for a bad date.
module dcw_mod import dcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  sum_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic valid_q;
  res_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.ok   = data_i.ok;
    data_d.wday = data_i.ok ? mod7(data_i.sum) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/date_check_and_weekday.sv
// An accepted item passes the div, check, sum and mod registers to the master side.
// One item per cycle unless the output stalls; four register stages, each with its own valid.
// A stage advances when it is empty or the stage after it advances, so bubbles
// fill up and a held output stalls only the stages behind full ones.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; no items pend.
`timescale 1ns / 1ps
`default_nettype none

`include "date_check_and_weekday_assert.svh"

module date_check_and_weekday import dcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [13:0] year, [17:14] month, [22:18] day, [23] zero
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [2:0] weekday, [7:3] zero
  output logic        m_axis_tuser_o    // [0] valid_res
);

  date_t in_date;
  div_t  div_data;
  chk_t  chk_data;
  sum_t  sum_data;
  res_t  res_data;

  logic div_valid, div_ready;
  logic chk_valid, chk_ready;
  logic sum_valid, sum_ready;

  // Unpack the input item, lowest field first.
  assign in_date.year  = s_axis_tdata_i[13:0];
  assign in_date.month = s_axis_tdata_i[17:14];
  assign in_date.day   = s_axis_tdata_i[22:18];

  // Stage 1: century by reciprocal multiply, Gregorian range check.
  dcw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (in_date),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data)
  );

  // Stage 2: leap year, month length, shifted-year century and year.
  dcw_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (div_ready),
    .data_i  (div_data),
    .valid_o (chk_valid),
    .ready_i (chk_ready),
    .data_o  (chk_data)
  );

  // Stage 3: Gauss weekday sum.
  dcw_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chk_valid),
    .ready_o (chk_ready),
    .data_i  (chk_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  // Stage 4: modulo 7, doubles as the output register.
  dcw_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (res_data)
  );

  assign m_axis_tdata_o = {5'd0, res_data.wday};
  assign m_axis_tuser_o = res_data.ok;

  // A refused input means every stage holds an item.
  `DCW_ASSERT_NOW(a_full_on_stall, !s_axis_tready_o,
                  div_valid && chk_valid && sum_valid && m_axis_tvalid_o,
                  "input refused while a stage is empty")

  // A bad date carries weekday zero.
  `DCW_ASSERT_NOW(a_bad_date_zero, m_axis_tvalid_o && !m_axis_tuser_o,
                  m_axis_tdata_o == 8'd0, "nonzero weekday on an invalid date")

  // The weekday never reaches seven and the padding stays zero.
  `DCW_ASSERT_NOW(a_wday_range, m_axis_tvalid_o,
                  m_axis_tdata_o[2:0] != 3'd7 && m_axis_tdata_o[7:3] == 5'd0,
                  "weekday out of range")

  // An item in stage 3 moves into an empty output register.
  `DCW_ASSERT_NEXT(a_drain, sum_valid && !m_axis_tvalid_o, m_axis_tvalid_o,
                   "stage 3 item not moved to the output")

endmodule

`default_nettype wire

// File: bench/tb_date_check_and_weekday.sv
`timescale 1ns / 1ps

module tb_date_check_and_weekday;
  import dcw_pkg::*;

  localparam int unsigned NumDirected = 25;
  localparam int unsigned RandomDates = 925;
  localparam int unsigned QuietFrom   = 200;  // random dates offered back to back
  localparam int unsigned QuietTo     = 350;
  localparam int unsigned HoldAt      = 450;  // dates taken before the long sink hold-off
  localparam int unsigned HoldOff     = 120;
  localparam int unsigned PauseAt     = 700;  // random date before which the source drains
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned MaxReports  = 40;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              known;  // typed result below is the expectation
    res_t              typed;
  } date_row_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // travel alongside the offered date so the checker knows its typed result
  logic        hint_known = 1'b0;
  res_t        hint_res   = '0;

  res_t        due_results[$];
  int unsigned dates_taken = 0;
  int unsigned mismatches  = 0;

  date_row_t directed_dates [NumDirected] = '{
    '{14'd1582,  4'd10, 5'd15, 1'b1, '{1'b1, 3'd5}},  // first Gregorian day, Friday
    '{14'd1582,  4'd10, 5'd14, 1'b1, '{1'b0, 3'd0}},  // last Julian day
    '{14'd1582,  4'd9,  5'd30, 1'b1, '{1'b0, 3'd0}},
    '{14'd1582,  4'd11, 5'd1,  1'b0, '{1'b0, 3'd0}},
    '{14'd1582,  4'd12, 5'd31, 1'b0, '{1'b0, 3'd0}},
    '{14'd1581,  4'd12, 5'd31, 1'b1, '{1'b0, 3'd0}},
    '{14'd1583,  4'd1,  5'd1,  1'b0, '{1'b0, 3'd0}},  // shifted year falls to 1582
    '{14'd9999,  4'd12, 5'd31, 1'b1, '{1'b1, 3'd5}},  // last day, Friday
    '{14'd10000, 4'd1,  5'd1,  1'b1, '{1'b0, 3'd0}},
    '{14'd16383, 4'd15, 5'd31, 1'b1, '{1'b0, 3'd0}},  // all ones
    '{14'd0,     4'd0,  5'd0,  1'b1, '{1'b0, 3'd0}},  // all zeros
    '{14'd2000,  4'd1,  5'd1,  1'b1, '{1'b1, 3'd6}},
    '{14'd2000,  4'd2,  5'd29, 1'b1, '{1'b1, 3'd2}},  // leap century
    '{14'd1900,  4'd2,  5'd29, 1'b1, '{1'b0, 3'd0}},  // century without leap day
    '{14'd1900,  4'd2,  5'd28, 1'b0, '{1'b0, 3'd0}},
    '{14'd2001,  4'd2,  5'd29, 1'b1, '{1'b0, 3'd0}},
    '{14'd2004,  4'd2,  5'd29, 1'b0, '{1'b0, 3'd0}},
    '{14'd2024,  4'd4,  5'd31, 1'b1, '{1'b0, 3'd0}},
    '{14'd2024,  4'd4,  5'd30, 1'b0, '{1'b0, 3'd0}},
    '{14'd2024,  4'd3,  5'd0,  1'b1, '{1'b0, 3'd0}},  // day zero
    '{14'd2024,  4'd0,  5'd10, 1'b1, '{1'b0, 3'd0}},  // month zero
    '{14'd2024,  4'd13, 5'd10, 1'b1, '{1'b0, 3'd0}},
    '{14'd2024,  4'd15, 5'd1,  1'b1, '{1'b0, 3'd0}},
    '{14'd2400,  4'd2,  5'd29, 1'b0, '{1'b0, 3'd0}},
    '{14'd2023,  4'd6,  5'd31, 1'b1, '{1'b0, 3'd0}}
  };

  date_check_and_weekday i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Validity and weekday of a date; Gauss's sum with March as month 1.
  function automatic res_t predict_date(input logic [YearW-1:0] yr,
                                        input logic [MonthW-1:0] mo,
                                        input logic [DayW-1:0] dy);
    int unsigned y, m, d, mlen, sm, ay, yy, cc, total;
    bit          leap, in_range;
    res_t        r;
    y    = yr;
    m    = mo;
    d    = dy;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: mlen = 31;
      4, 6, 9, 11:           mlen = 30;
      2:                     mlen = leap ? 29 : 28;
      default:               mlen = 0;
    endcase
    in_range = (y > FirstYear && y <= LastYear) ||
               (y == FirstYear && (m > FirstMonth || (m == FirstMonth && d > LastJulDay)));
    r = '0;
    if (in_range && d != 0 && d <= mlen) begin
      sm      = 1 + (m + 9) % 12;
      ay      = (m < MarchMonth) ? y - 1 : y;
      yy      = ay % 100;
      cc      = ay / 100;
      total   = d + (13 * sm - 1) / 5 + yy + yy / 4 + cc / 4 + 5 * cc;
      r.ok    = 1'b1;
      r.wday  = WdayW'(total % 7);
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the date on the bus until the block takes it.
  task automatic offer_date(input logic [YearW-1:0] yr, input logic [MonthW-1:0] mo,
                            input logic [DayW-1:0] dy, input logic known,
                            input res_t typed, input int unsigned gap);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, dy, mo, yr};
    hint_known      <= known;
    hint_res        <= typed;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Mostly plausible dates; the rest aims at the calendar edges or is pure noise.
  task automatic draw_date(output logic [YearW-1:0] yr, output logic [MonthW-1:0] mo,
                           output logic [DayW-1:0] dy);
    case ($urandom_range(0, 9))
      0: begin
        yr = YearW'($urandom);
        mo = MonthW'($urandom);
        dy = DayW'($urandom);
      end
      1: begin
        yr = FirstYear;
        mo = MonthW'($urandom_range(9, 12));
        dy = DayW'($urandom_range(0, 31));
      end
      2: begin
        yr = YearW'(100 * $urandom_range(16, 99) + $urandom_range(0, 1) * 4);
        mo = 4'd2;
        dy = DayW'($urandom_range(27, 30));
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       yr = FirstYear - 14'd1;
          1:       yr = FirstYear + 14'd1;
          2:       yr = LastYear;
          default: yr = LastYear + 14'd1;
        endcase
        mo = MonthW'($urandom_range(0, 15));
        dy = DayW'($urandom_range(0, 31));
      end
      default: begin
        yr = YearW'($urandom_range(1583, 9999));
        mo = MonthW'($urandom_range(1, 12));
        dy = DayW'($urandom_range(1, 31));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [YearW-1:0]  yr;
    logic [MonthW-1:0] mo;
    logic [DayW-1:0]   dy;
    int unsigned       gap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_dates[i]) begin
      offer_date(directed_dates[i].year, directed_dates[i].month, directed_dates[i].day,
                 directed_dates[i].known, directed_dates[i].typed, idle_len());
    end
    for (int unsigned i = 0; i < RandomDates; i++) begin
      gap = (i >= QuietFrom && i < QuietTo) ? 0 : idle_len();
      if (i == PauseAt) begin
        // drain: hold the source until every result is in
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (due_results.size() != 0);
        gap = 0;
      end
      draw_date(yr, mo, dy);
      offer_date(yr, mo, dy, 1'b0, '0, gap);
    end
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result sink: random ready runs and stalls, one long hold-off to back up the pipe.
  initial begin : result_sink
    int unsigned run_left, stall_left;
    bit          held;
    run_left   = 0;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (!held && dates_taken >= HoldAt) begin
          held       = 1'b1;
          stall_left = HoldOff;
          run_left   = 0;
        end else if (stall_left == 0 && run_left == 0) begin
          run_left   = $urandom_range(1, 16);
          stall_left = (dates_taken >= QuietFrom && dates_taken < QuietTo) ? 0 : idle_len();
        end
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready_i <= 1'b0;
        end else begin
          run_left--;
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  // Record each taken date's expectation, check each delivered result in order.
  always @(posedge clk_i) begin : result_check
    res_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.ok   = m_axis_tuser_o;
        got.wday = m_axis_tdata_o[WdayW-1:0];
        if (due_results.size() == 0) begin
          if (mismatches < MaxReports)
            $display("%0t: unexpected result, expected none, actual valid=%0b weekday=%0d",
                     $time, got.ok, got.wday);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.ok !== want.ok) begin
            if (mismatches < MaxReports)
              $display("%0t: valid_res expected %0b actual %0b", $time, want.ok, got.ok);
            mismatches++;
          end
          if (got.wday !== want.wday) begin
            if (mismatches < MaxReports)
              $display("%0t: weekday expected %0d actual %0d", $time, want.wday, got.wday);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        due_results.push_back(hint_known ? hint_res :
                              predict_date(s_axis_tdata_i[13:0], s_axis_tdata_i[17:14],
                                           s_axis_tdata_i[22:18]));
        dates_taken++;
      end
    end
  end

  // Abort when neither side moves an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (rst_ni && !((s_axis_tvalid_i && s_axis_tready_o) ||
                      (m_axis_tvalid_o && m_axis_tready_i)))
        quiet++;
      else
        quiet = 0;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
